### src/binomial_coefficient_unit_defines.svh
`ifndef BINOMIAL_COEFFICIENT_UNIT_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_UNIT_DEFINES_SVH

// same-cycle implication
`define BCU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcu assertion failed");

// next-cycle implication
`define BCU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcu assertion failed");

`endif

### src/bcu_pkg.sv
package bcu_pkg;

   localparam int FIELD_W         = 6;
   localparam int COEF_W          = 64;
   localparam int ACC_W           = COEF_W + FIELD_W;
   localparam int BIT_W           = $clog2(ACC_W);
   localparam int MAX_SET_DEFAULT = 63;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SETUP  = 5'b00010,
      ST_MUL    = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div_step;
      logic next_iter;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic kk_zero;
      logic div_last;
      logic iter_last;
   } stat_type;

endpackage

### src/bcu_ctrl.sv
module bcu_ctrl
   import bcu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (stat.bad || stat.kk_zero) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               cmd.next_iter = 1'b1;
               state_in      = stat.iter_last ? ST_FINISH : ST_MUL;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### src/bcu_datapath.sv
module bcu_datapath
   import bcu_pkg::*;
#(
   parameter int MAX_SET = MAX_SET_DEFAULT
) (
   input  logic               clock,
   input  logic [FIELD_W-1:0] req_set_size,
   input  logic [FIELD_W-1:0] req_choose_count,
   output logic [COEF_W-1:0]  rsp_coefficient,
   input  cmd_type            cmd,
   output stat_type           stat
);

   logic [FIELD_W-1:0] n_ff, n_in;
   logic [FIELD_W-1:0] kk_ff, kk_in;
   logic [FIELD_W-1:0] i_ff, i_in;
   logic               bad_ff, bad_in;
   logic [COEF_W-1:0]  c_ff, c_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [FIELD_W-1:0] rem_ff, rem_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [COEF_W-1:0]  coef_ff, coef_in;

   logic [FIELD_W-1:0] diff_nk;
   logic [FIELD_W-1:0] divisor;
   logic [FIELD_W:0]   shifted;
   logic [FIELD_W:0]   sub;
   logic               ge;
   logic [ACC_W-1:0]   acc_step;

   assign diff_nk  = req_set_size - req_choose_count;
   assign divisor  = i_ff + 1'b1;
   assign shifted  = {rem_ff, acc_ff[ACC_W-1]};
   assign sub      = shifted - {1'b0, divisor};
   assign ge       = (shifted >= {1'b0, divisor});
   assign acc_step = {acc_ff[ACC_W-2:0], ge};

   always_comb begin
      n_in    = n_ff;
      kk_in   = kk_ff;
      i_in    = i_ff;
      bad_in  = bad_ff;
      c_in    = c_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      bit_in  = bit_ff;
      coef_in = coef_ff;
      if (cmd.load) begin
         n_in   = req_set_size;
         bad_in = (req_set_size > FIELD_W'(MAX_SET)) || (req_choose_count > req_set_size);
         kk_in  = (req_choose_count > diff_nk) ? diff_nk : req_choose_count;
         i_in   = '0;
         c_in   = COEF_W'(1);
      end
      // 64 x 6 product, at most 70 bits
      if (cmd.mul) begin
         acc_in = ACC_W'(c_ff) * ACC_W'(n_ff - i_ff);
         rem_in = '0;
         bit_in = BIT_W'(ACC_W - 1);
      end
      // restoring division, one quotient bit per cycle
      if (cmd.div_step) begin
         acc_in = acc_step;
         rem_in = ge ? sub[FIELD_W-1:0] : shifted[FIELD_W-1:0];
         bit_in = bit_ff - 1'b1;
      end
      if (cmd.next_iter) begin
         c_in = acc_step[COEF_W-1:0];
         i_in = i_ff + 1'b1;
      end
      if (cmd.out_load) begin
         coef_in = bad_ff ? '0 : c_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      kk_ff   <= kk_in;
      i_ff    <= i_in;
      bad_ff  <= bad_in;
      c_ff    <= c_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      bit_ff  <= bit_in;
      coef_ff <= coef_in;
   end

   assign stat.bad       = bad_ff;
   assign stat.kk_zero   = (kk_ff == '0);
   assign stat.div_last  = (bit_ff == '0);
   assign stat.iter_last = (divisor == kk_ff);

   assign rsp_coefficient = coef_ff;

endmodule

### src/binomial_coefficient_unit.sv
// channel  ports                                  word
// req      req_valid / req_stall                  set_size (6b), choose_count (6b)
// rsp      rsp_valid / rsp_stall                  coefficient (64b)
//
// A word runs min(k, n-k) iterations from ST_SETUP to ST_FINISH; the result
// and rsp_valid are registered together when ST_FINISH loads the output.
// Each iteration is a 64x6 multiply in ST_MUL followed by the bit-serial
// divider in ST_DIV; one word is in flight at a time.
// Reset clears the controller state and the result valid; no clearing pass.
// A stalled result holds in its register while the next word is taken.
`include "binomial_coefficient_unit_defines.svh"

module binomial_coefficient_unit
   import bcu_pkg::*;
#(
   parameter int MAX_SET = MAX_SET_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FIELD_W-1:0] req_set_size,
   input  logic [FIELD_W-1:0] req_choose_count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COEF_W-1:0]  rsp_coefficient
);

   cmd_type  cmd;
   stat_type stat;

   bcu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bcu_datapath #(
      .MAX_SET (MAX_SET)
   ) u_datapath (
      .clock            (clock),
      .req_set_size     (req_set_size),
      .req_choose_count (req_choose_count),
      .rsp_coefficient  (rsp_coefficient),
      .cmd              (cmd),
      .stat             (stat)
   );

   `BCU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `BCU_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.out_load, !rsp_valid || !rsp_stall)
   `BCU_ASSERT_NEXT(a_mul_then_div, clock, reset, cmd.mul, cmd.div_step)

endmodule

### tb/sv/bcu_coefficient_checker.sv
`timescale 1ns / 100ps

module bcu_coefficient_checker
   import bcu_pkg::*;
#(
   parameter int MAX_SET = MAX_SET_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [FIELD_W-1:0] req_set_size,
   input  logic [FIELD_W-1:0] req_choose_count,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [COEF_W-1:0]  rsp_coefficient,
   output int                 error_count,
   output int                 pending_count
);

   logic [COEF_W-1:0] coef_due[$];
   int                mismatch_total = 0;

   // c = c * (n - i) / (i + 1), every step exact, 70-bit intermediate
   function automatic logic [COEF_W-1:0] choose_exact(input logic [FIELD_W-1:0] n,
                                                      input logic [FIELD_W-1:0] k);
      logic [ACC_W-1:0] acc;
      int unsigned      kk;
      if (n > MAX_SET || k > n) begin
         return '0;
      end
      kk  = (k > n - k) ? 32'(n - k) : 32'(k);
      acc = ACC_W'(1);
      for (int unsigned i = 0; i < kk; i++) begin
         acc = acc * ACC_W'(n - i) / ACC_W'(i + 1);
      end
      return acc[COEF_W-1:0];
   endfunction

   always @(posedge clock) begin
      logic [COEF_W-1:0] want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            coef_due = {coef_due, choose_exact(req_set_size, req_choose_count)};
         end
         if (rsp_valid && !rsp_stall) begin
            if (coef_due.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %0d",
                        $time, rsp_coefficient);
               mismatch_total++;
            end else begin
               want = coef_due.pop_front();
               if (rsp_coefficient !== want) begin
                  $display("%0t: coefficient mismatch, expected %0d, actual %0d",
                           $time, want, rsp_coefficient);
                  mismatch_total++;
               end
            end
         end
      end
      error_count   <= mismatch_total;
      pending_count <= coef_due.size();
   end

endmodule

### tb/sv/tb_binomial_coefficient_unit.sv
`timescale 1ns / 100ps

module tb_binomial_coefficient_unit;
   import bcu_pkg::*;

   localparam int RANDOM_WORDS = 250;
   localparam int QUIET_FROM   = 210;
   localparam int DRAIN_CYCLES = 2300;
   localparam int STALL_LIMIT  = 20000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [FIELD_W-1:0] req_set_size;
   logic [FIELD_W-1:0] req_choose_count;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [COEF_W-1:0]  rsp_coefficient;
   int                 error_count;
   int                 pending_count;
   bit                 quiet;

   binomial_coefficient_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_set_size     (req_set_size),
      .req_choose_count (req_choose_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_coefficient  (rsp_coefficient)
   );

   bcu_coefficient_checker u_chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_set_size     (req_set_size),
      .req_choose_count (req_choose_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_coefficient  (rsp_coefficient),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side stalls in bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // no-progress watchdog
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_pair(input logic [FIELD_W-1:0] n, input logic [FIELD_W-1:0] k);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_set_size     <= n;
      req_choose_count <= k;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      logic [FIELD_W-1:0] n;
      logic [FIELD_W-1:0] k;
      quiet            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_set_size     = '0;
      req_choose_count = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // edges, symmetry, k > n
      send_pair(0, 0);
      send_pair(63, 0);
      send_pair(63, 63);
      send_pair(63, 31);
      send_pair(63, 32);
      send_pair(62, 31);
      send_pair(63, 1);
      send_pair(63, 62);
      send_pair(0, 63);
      send_pair(1, 63);
      send_pair(62, 63);
      send_pair(5, 6);
      send_pair(1, 0);
      send_pair(1, 1);
      send_pair(10, 3);
      send_pair(42, 21);
      send_pair(60, 30);
      send_pair(32, 16);

      for (int idx = 0; idx < RANDOM_WORDS; idx++) begin
         if (idx == RANDOM_WORDS / 2) begin
            req_valid <= 1'b0;
            wait_drained();
         end
         if (idx == QUIET_FROM) begin
            quiet = 1'b1;
         end
         n = FIELD_W'($urandom_range(0, 63));
         if ($urandom_range(0, 3) != 0) begin
            k = FIELD_W'($urandom_range(0, n));
         end else begin
            k = FIELD_W'($urandom_range(0, 63));
         end
         send_pair(n, k);
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### files.f
+incdir+src
src/bcu_pkg.sv
src/bcu_ctrl.sv
src/bcu_datapath.sv
src/binomial_coefficient_unit.sv
tb/sv/bcu_coefficient_checker.sv
tb/sv/tb_binomial_coefficient_unit.sv
